// ===== sv/kec_pkg.sv =====
// ----------------------------------------------------------------------------
// kec_pkg: shared types and constants of the keyboard encoder command port
// Command codes, queue sizing, the opcode type and the structs that travel
// between the command decoder, the response queue and the countdown timers.
// ----------------------------------------------------------------------------
package kec_pkg;

  // Response queue sizing
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Command bytes
  localparam logic [7:0] CMD_MODE_WRITE  = 8'h00;
  localparam logic [7:0] CMD_MODE_QUERY  = 8'h01;
  localparam logic [7:0] CMD_LAMP_WRITE  = 8'h02;
  localparam logic [7:0] CMD_LAMP_QUERY  = 8'h03;
  localparam logic [7:0] CMD_AUTO_REPEAT = 8'h04;
  localparam logic [7:0] CMD_REPEAT_TIME = 8'h05;
  localparam logic [7:0] CMD_CLOCK       = 8'h80;
  localparam logic [7:0] CMD_DIGITIZE    = 8'h81;
  localparam logic [7:0] CMD_SET_SCREEN  = 8'h82;
  localparam logic [7:0] CMD_GET_SCREEN  = 8'h83;
  localparam logic [7:0] CMD_BRIGHTNESS  = 8'h84;
  localparam logic [7:0] CMD_NONE        = 8'hFF;

  // Parameter codes
  localparam logic [7:0] MODE_MAX      = 8'd2;
  localparam logic [7:0] LED_CAPS_ON   = 8'd0;
  localparam logic [7:0] LED_CAPS_OFF  = 8'd1;
  localparam logic [7:0] LED_KANA_ON   = 8'd2;
  localparam logic [7:0] LED_KANA_OFF  = 8'd3;
  localparam logic [7:0] REPEAT_ON     = 8'd0;
  localparam logic [7:0] REPEAT_OFF    = 8'd1;
  localparam logic [7:0] CLOCK_READ    = 8'd0;
  localparam logic [7:0] CLOCK_WRITE   = 8'd1;
  localparam logic [3:0] CLOCK_WRITE_BYTES = 4'd8;
  localparam int         CLOCK_ZERO_BYTES  = 7;

  // Status byte
  localparam logic [7:0] STATUS_IDLE       = 8'hFF;
  localparam int         STATUS_BUSY_BIT   = 0;
  localparam int         STATUS_NREADY_BIT = 7;

  // Configuration registers
  localparam int         CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_DELAY = 1'd1;
  localparam logic [15:0] DELAY_RESET    = 16'd100;

  // Settings that the set commands change
  typedef struct packed {
    logic [1:0] coding_mode;
    logic       caps_led;
    logic       kana_led;
    logic       repeat_enabled;
    logic [7:0] repeat_start;
    logic [7:0] repeat_interval;
    logic [7:0] screen_mode;
    logic [7:0] tv_brightness;
  } settings_t;

  localparam settings_t SETTINGS_RESET = '{
    coding_mode:     2'd0,
    caps_led:        1'b0,
    kana_led:        1'b0,
    repeat_enabled:  1'b1,
    repeat_start:    8'd70,
    repeat_interval: 8'd7,
    screen_mode:     8'd0,
    tv_brightness:   8'd0
  };

  // Queue request from the command decoder
  typedef struct packed {
    logic       clear;
    logic       push_one;
    logic       push_zeros;
    logic [7:0] value;
  } qreq_t;

  // Countdown status after the update
  typedef struct packed {
    logic busy;
    logic hold_ready;
  } tstat_t;

endpackage

// ===== sv/kec_if.sv =====
// ----------------------------------------------------------------------------
// kec_if: channel interfaces of the keyboard encoder command port
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kec_req_if;
  import kec_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface kec_rsp_if;
  import kec_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] read_data;
  logic [1:0] coding_mode;
  logic       caps_led;
  logic       kana_led;
  logic       repeat_enabled;
  logic [7:0] repeat_start;
  logic [7:0] repeat_interval;
  logic [7:0] screen_mode;
  logic [7:0] tv_brightness;
  modport source (output valid, output status_byte, output read_data, output coding_mode,
                  output caps_led, output kana_led, output repeat_enabled,
                  output repeat_start, output repeat_interval, output screen_mode,
                  output tv_brightness, input ready);
  modport sink   (input valid, input status_byte, input read_data, input coding_mode,
                  input caps_led, input kana_led, input repeat_enabled,
                  input repeat_start, input repeat_interval, input screen_mode,
                  input tv_brightness, output ready);
endinterface

interface kec_cfg_if;
  import kec_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/kec_cmd.sv =====
// ----------------------------------------------------------------------------
// kec_cmd: command decoder
// Tracks the pending command and its parameter bytes, updates the settings
// and issues queue requests for the get and clock commands.
// ----------------------------------------------------------------------------
module kec_cmd (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [7:0]        wr_data,
  output kec_pkg::settings_t settings_next,
  output kec_pkg::qreq_t     qreq
);
  import kec_pkg::*;

  logic [7:0] pending, pending_next;
  logic [3:0] param_count, param_count_next;
  logic [7:0] param_first, param_first_next;
  settings_t  settings;

  // Decode one written byte against the pending command
  always_comb begin
    pending_next     = pending;
    param_count_next = param_count;
    param_first_next = param_first;
    settings_next    = settings;
    qreq             = '0;
    if (wr_en) begin
      case (pending)
        CMD_MODE_WRITE: begin
          if (wr_data <= MODE_MAX) settings_next.coding_mode = wr_data[1:0];
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        CMD_LAMP_WRITE: begin
          if (wr_data == LED_CAPS_ON)       settings_next.caps_led = 1'b1;
          else if (wr_data == LED_CAPS_OFF) settings_next.caps_led = 1'b0;
          else if (wr_data == LED_KANA_ON)  settings_next.kana_led = 1'b1;
          else if (wr_data == LED_KANA_OFF) settings_next.kana_led = 1'b0;
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        CMD_AUTO_REPEAT: begin
          if (wr_data == REPEAT_ON)       settings_next.repeat_enabled = 1'b1;
          else if (wr_data == REPEAT_OFF) settings_next.repeat_enabled = 1'b0;
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        CMD_REPEAT_TIME: begin
          if (param_count == '0) begin
            param_first_next = wr_data;
            param_count_next = 4'd1;
          end else begin
            settings_next.repeat_start    = param_first;
            settings_next.repeat_interval = wr_data;
            pending_next     = CMD_NONE;
            param_count_next = '0;
          end
        end
        CMD_CLOCK: begin
          if (param_count == '0) begin
            if (wr_data == CLOCK_READ) begin
              qreq.push_zeros  = 1'b1;
              pending_next     = CMD_NONE;
              param_count_next = '0;
            end else if (wr_data == CLOCK_WRITE) begin
              param_first_next = wr_data;
              param_count_next = 4'd1;
            end else begin
              pending_next     = CMD_NONE;
              param_count_next = '0;
            end
          end else begin
            // skip the clock bytes until all have arrived
            param_count_next = param_count + 4'd1;
            if (param_count_next >= CLOCK_WRITE_BYTES) begin
              pending_next     = CMD_NONE;
              param_count_next = '0;
            end
          end
        end
        CMD_DIGITIZE: begin
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        CMD_SET_SCREEN: begin
          settings_next.screen_mode = wr_data;
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        CMD_BRIGHTNESS: begin
          settings_next.tv_brightness = wr_data;
          pending_next     = CMD_NONE;
          param_count_next = '0;
        end
        default: begin
          // take the byte as a new command
          pending_next     = wr_data;
          param_count_next = '0;
          if (wr_data == CMD_MODE_QUERY) begin
            qreq.clear     = 1'b1;
            qreq.push_one  = 1'b1;
            qreq.value     = {6'd0, settings.coding_mode};
            pending_next   = CMD_NONE;
          end else if (wr_data == CMD_LAMP_QUERY) begin
            qreq.clear     = 1'b1;
            qreq.push_one  = 1'b1;
            qreq.value     = {6'd0, settings.kana_led, settings.caps_led};
            pending_next   = CMD_NONE;
          end else if (wr_data == CMD_GET_SCREEN) begin
            qreq.clear     = 1'b1;
            qreq.push_one  = 1'b1;
            qreq.value     = settings.screen_mode;
            pending_next   = CMD_NONE;
          end
        end
      endcase
    end
  end

  // Hold command state and settings
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= CMD_NONE;
      param_count <= '0;
      settings    <= SETTINGS_RESET;
    end else begin
      pending     <= pending_next;
      param_count <= param_count_next;
      settings    <= settings_next;
    end
  end

  // Parameter byte needs no reset
  always_ff @(posedge clk) begin
    param_first <= param_first_next;
  end

endmodule

// ===== sv/kec_queue.sv =====
// ----------------------------------------------------------------------------
// kec_queue: response byte queue
// Circular buffer of response bytes with clear, single push, burst push of
// zero bytes for the clock read, and pop on a data read.
// ----------------------------------------------------------------------------
module kec_queue (
  input  logic           clk,
  input  logic           rst,
  input  kec_pkg::qreq_t qreq,
  input  logic           pop_en,
  output logic [7:0]     pop_data,
  output logic           nonempty_next
);
  import kec_pkg::*;

  logic [7:0]        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head, head_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [PTR_W-1:0]  base_head;
  logic [FILL_W-1:0] base_fill;
  logic [FILL_W-1:0] space;
  logic [FILL_W-1:0] push_req;
  logic [FILL_W-1:0] push_n;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail;
  logic [QUEUE_DEPTH-1:0] wr_mask;
  logic [7:0]        wr_value;
  logic              do_pop;

  // Place pushed bytes after the tail, as many as there is room for
  always_comb begin
    base_head = qreq.clear ? '0 : head;
    base_fill = qreq.clear ? '0 : fill;
    space     = FILL_W'(QUEUE_DEPTH) - base_fill;
    if (qreq.push_one)        push_req = FILL_W'(1);
    else if (qreq.push_zeros) push_req = FILL_W'(CLOCK_ZERO_BYTES);
    else                      push_req = '0;
    push_n   = (push_req < space) ? push_req : space;
    wr_value = qreq.push_one ? qreq.value : 8'd0;
    tail_sum = SUM_W'(base_head) + SUM_W'(base_fill);
    tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
  end

  always_comb begin
    logic [SUM_W-1:0] jw;
    logic [SUM_W-1:0] offset;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      jw     = SUM_W'(j);
      offset = (jw >= tail) ? jw - tail : jw + SUM_W'(QUEUE_DEPTH) - tail;
      wr_mask[j] = offset < SUM_W'(push_n);
    end
  end

  // Pop from the head
  always_comb begin
    do_pop   = pop_en && (fill != '0);
    pop_data = do_pop ? mem[head] : 8'd0;
    if (qreq.clear) begin
      head_next = '0;
    end else if (do_pop) begin
      head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
    end else begin
      head_next = head;
    end
    fill_next     = base_fill + push_n - FILL_W'(do_pop);
    nonempty_next = fill_next != '0;
  end

  // Hold pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // Write queue entries
  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (wr_mask[j]) mem[j] <= wr_value;
    end
  end

endmodule

// ===== sv/kec_timer.sv =====
// ----------------------------------------------------------------------------
// kec_timer: acknowledge and ready countdowns
// Holds the two delay registers, reloads the countdowns on command writes and
// data reads, and counts them down on ticks.
// ----------------------------------------------------------------------------
module kec_timer (
  input  logic             clk,
  input  logic             rst,
  kec_cfg_if.sink          cfg,
  input  logic             op_en,
  input  kec_pkg::op_t     opcode,
  output kec_pkg::tstat_t  tstat
);
  import kec_pkg::*;

  logic [15:0] ack_delay;
  logic [15:0] ready_delay;
  logic [15:0] ack_count, ack_count_next;
  logic [15:0] ready_count, ready_count_next;

  assign cfg.ready = 1'b1;

  // Reload or count down
  always_comb begin
    ack_count_next   = ack_count;
    ready_count_next = ready_count;
    if (op_en) begin
      case (opcode)
        OP_WRITE: ack_count_next   = ack_delay;
        OP_READ:  ready_count_next = ready_delay;
        OP_TICK: begin
          if (ack_count != '0)   ack_count_next   = ack_count - 16'd1;
          if (ready_count != '0) ready_count_next = ready_count - 16'd1;
        end
        default: begin
        end
      endcase
    end
    tstat.busy       = ack_count_next != '0;
    tstat.hold_ready = ready_count_next != '0;
  end

  // Hold counters and delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_count   <= '0;
      ready_count <= '0;
      ack_delay   <= DELAY_RESET;
      ready_delay <= DELAY_RESET;
    end else begin
      ack_count   <= ack_count_next;
      ready_count <= ready_count_next;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_ACK_DELAY:   ack_delay   <= cfg.data;
          CFG_READY_DELAY: ready_delay <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/keyboard_encoder_command_port_top.sv =====
// ----------------------------------------------------------------------------
// keyboard_encoder_command_port_top: keyboard encoder command port
// Host-side command interface of a keyboard encoder: command decode, response
// queue, busy and data-ready countdowns, and a registered response.
// ----------------------------------------------------------------------------
// Each request (a command or parameter byte write, a data read or a tick)
// produces exactly one response, which appears in the output register on the
// cycle after the request is accepted. A request is taken every cycle as long
// as the response register is empty or is being drained in the same cycle, so
// the sustained rate is one request per clock; the single response register
// is the only buffering, and a stalled response holds off new requests. The
// clock-read command fills up to seven queue entries at once. Status bit 0
// is low while the acknowledge countdown runs and bit 7 is low when queued data
// is ready to read.
module keyboard_encoder_command_port_top (
  input  logic      clk,
  input  logic      rst,
  kec_req_if.sink   req,
  kec_rsp_if.source rsp,
  kec_cfg_if.sink   cfg
);
  import kec_pkg::*;

  logic      accept;
  op_t       opcode;
  settings_t settings_next;
  qreq_t     qreq;
  tstat_t    tstat;
  logic [7:0] pop_data;
  logic      nonempty_next;
  logic [7:0] status_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign opcode    = op_t'(req.opcode);

  kec_cmd u_cmd (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (accept && (opcode == OP_WRITE)),
    .wr_data       (req.data_byte),
    .settings_next (settings_next),
    .qreq          (qreq)
  );

  kec_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .qreq          (qreq),
    .pop_en        (accept && (opcode == OP_READ)),
    .pop_data      (pop_data),
    .nonempty_next (nonempty_next)
  );

  kec_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .op_en  (accept),
    .opcode (opcode),
    .tstat  (tstat)
  );

  // Build the status byte from the updated state
  always_comb begin
    status_next = STATUS_IDLE;
    if (tstat.busy) status_next[STATUS_BUSY_BIT] = 1'b0;
    if (nonempty_next && !tstat.hold_ready) status_next[STATUS_NREADY_BIT] = 1'b0;
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status_byte     <= status_next;
      rsp.read_data       <= pop_data;
      rsp.coding_mode     <= settings_next.coding_mode;
      rsp.caps_led        <= settings_next.caps_led;
      rsp.kana_led        <= settings_next.kana_led;
      rsp.repeat_enabled  <= settings_next.repeat_enabled;
      rsp.repeat_start    <= settings_next.repeat_start;
      rsp.repeat_interval <= settings_next.repeat_interval;
      rsp.screen_mode     <= settings_next.screen_mode;
      rsp.tv_brightness   <= settings_next.tv_brightness;
    end
  end

endmodule

// ===== sv/kec_checker.sv =====
// ----------------------------------------------------------------------------
// kec_checker: port-level checks of the keyboard encoder command port
// Watches requests and responses at the top level and flags bad responses.
// ----------------------------------------------------------------------------
module kec_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_opcode,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_status_byte,
  input logic [7:0] rsp_read_data,
  input logic [1:0] rsp_coding_mode
);
  import kec_pkg::*;

  // Only a data read returns a byte
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_opcode != OP_READ)) |=> (rsp_read_data == 8'd0))
    else $error("read_data nonzero on a response to a non-read request");

  // Coding mode never leaves its legal range
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_coding_mode != 2'd3))
    else $error("coding_mode out of range");

  // Unused status bits stay high
  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status_byte[6:1] == 6'h3F))
    else $error("reserved status bits not set");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status_byte)
                                   && $stable(rsp_read_data)))
    else $error("stalled response changed");

endmodule

bind keyboard_encoder_command_port_top kec_checker u_kec_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_opcode      (req.opcode),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status_byte (rsp.status_byte),
  .rsp_read_data   (rsp.read_data),
  .rsp_coding_mode (rsp.coding_mode)
);
